>>> rtl/kwm_pkg.sv
// Package for the k-way timestamp merge: result kinds, opcodes, and the
// command/status structs between controller and datapath. No dependencies.
package kwm_pkg;
    localparam logic       OP_LOAD     = 1'b0;
    localparam logic       OP_POP      = 1'b1;
    localparam logic [1:0] KIND_POINT  = 2'd0;
    localparam logic [1:0] KIND_REFILL = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    typedef struct packed {
        logic clear;     // start a scan
        logic scan;      // fold one source into min/winner
        logic emit;      // step the removal walk
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic hit;       // walk cursor points at a removed non-winner
        logic walk_done; // no removed non-winner left at or beyond the cursor
    } t_sts;
endpackage

>>> rtl/kwm_datapath.sv
// Datapath of the k-way merge: head storage, valid bits, the scan unit that
// finds the minimum stamp and winner, and the removal walk. Uses kwm_pkg.
module kwm_datapath #(
    parameter int SOURCES = 16,
    parameter int IW = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kwm_pkg::t_cmd        i_cmd,
    output kwm_pkg::t_sts        o_sts,
    input  logic                 i_load,
    input  logic [3:0]           i_source,
    input  logic [63:0]          i_stamp,
    input  logic [63:0]          i_payload,
    input  logic [31:0]          i_sequence_req,
    output logic [63:0]          o_min_stamp,
    output logic [63:0]          o_win_payload,
    output logic [3:0]           o_win_source,
    output logic [3:0]           o_walk_source
);
    logic [63:0] r_stamp [SOURCES];
    logic [63:0] r_payload [SOURCES];
    logic [31:0] r_seq [SOURCES];
    logic [SOURCES-1:0] r_present;
    logic [IW-1:0] r_idx;
    logic          r_found;
    logic [63:0]   r_min;
    logic [31:0]   r_wseq;
    logic [IW-1:0] r_win;
    logic [SOURCES-1:0] r_rm;   // sources to remove, excluding the winner
    logic [IW-1:0] idx;
    logic [IW-1:0] ld_idx;
    logic          sel, take_min, eq_min, beat_win;
    logic          hit, more;

    assign idx = r_idx;
    assign ld_idx = IW'(i_source);
    assign sel = r_present[r_idx];
    assign take_min = sel && (!r_found || r_stamp[idx] < r_min);
    assign eq_min = sel && r_found && r_stamp[idx] == r_min;
    assign beat_win = eq_min && r_seq[idx] > r_wseq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_found   <= 1'b0;
            r_idx     <= '0;
            r_rm      <= '0;
        end else begin
            if (i_load && ({2'b0, i_source} < 6'(SOURCES)) && !r_present[ld_idx]) begin
                r_stamp[ld_idx]   <= i_stamp;
                r_payload[ld_idx] <= i_payload;
                r_seq[ld_idx]     <= i_sequence_req;
                r_present[ld_idx] <= 1'b1;
            end
            if (i_cmd.clear) begin
                r_idx   <= '0;
                r_found <= 1'b0;
                r_rm    <= '0;
            end else if (i_cmd.scan) begin
                r_idx <= (r_idx == IW'(SOURCES - 1)) ? '0 : r_idx + 1'b1;
                if (take_min) begin
                    r_found <= 1'b1;
                    r_min   <= r_stamp[idx];
                    r_wseq  <= r_seq[idx];
                    r_win   <= idx;
                    r_rm    <= '0;
                end else if (eq_min) begin
                    if (beat_win) begin
                        r_rm[r_win] <= 1'b1;
                        r_wseq <= r_seq[idx];
                        r_win  <= idx;
                    end else begin
                        r_rm[idx] <= 1'b1;
                    end
                end
            end else if (i_cmd.emit) begin
                // drop the head at the cursor, or the winner at the end
                if (more || hit) begin
                    if (hit) begin
                        r_present[r_idx] <= 1'b0;
                        r_rm[r_idx]      <= 1'b0;
                    end
                    r_idx <= r_idx + 1'b1;
                end else begin
                    r_present[r_win] <= 1'b0;
                end
            end
        end
    end

    logic [SOURCES-1:0] above;
    always_comb begin
        for (int k = 0; k < SOURCES; k++) above[k] = (IW'(k) > r_idx) && r_rm[k];
    end

    assign hit           = r_rm[r_idx];
    assign more          = |above;
    assign o_walk_source = 4'(r_idx);
    assign o_min_stamp   = r_min;
    assign o_win_payload = r_payload[r_win];
    assign o_win_source  = 4'(r_win);
    assign o_sts.scan_done = (r_idx == IW'(SOURCES - 1));
    assign o_sts.found     = r_found || take_min;
    assign o_sts.hit       = hit;
    assign o_sts.walk_done = !(more || hit);
endmodule

>>> rtl/kwm_ctrl.sv
// Controller of the k-way merge: sequences the scan and the result walk and
// drives the output register. Uses kwm_pkg.
module kwm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_opcode,
    output kwm_pkg::t_cmd o_cmd,
    input  kwm_pkg::t_sts i_sts,
    output logic          o_load,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [1:0]    o_kind,
    output logic          o_last,
    output logic          o_cap,
    output logic [1:0]    o_cap_kind
);
    localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_POINT = 3'd2,
                           S_WALK = 3'd3, S_EMPTY = 3'd4;
    logic [2:0] r_state, n_state;
    logic       free;
    logic       cap_last;

    assign free   = !o_out_valid || i_out_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_load = i_valid && o_ready && i_opcode == kwm_pkg::OP_LOAD;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: if (i_valid && i_opcode == kwm_pkg::OP_POP) begin
                o_cmd.clear = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) n_state = i_sts.found ? S_POINT : S_EMPTY;
            end
            S_POINT: if (free) n_state = S_WALK;
            S_WALK: if (free) begin
                o_cmd.emit = 1'b1;
                if (i_sts.walk_done) n_state = S_IDLE;
            end
            S_EMPTY: if (free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // load a result beat only for the point, the empty marker and removed sources
    always_comb begin
        o_cap      = 1'b0;
        o_cap_kind = kwm_pkg::KIND_REFILL;
        cap_last   = 1'b0;
        if (free) begin
            case (r_state)
                S_POINT: begin
                    o_cap      = 1'b1;
                    o_cap_kind = kwm_pkg::KIND_POINT;
                end
                S_EMPTY: begin
                    o_cap      = 1'b1;
                    o_cap_kind = kwm_pkg::KIND_EMPTY;
                    cap_last   = 1'b1;
                end
                S_WALK: begin
                    o_cap    = i_sts.hit || i_sts.walk_done;
                    cap_last = i_sts.walk_done;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cap) begin
                o_out_valid <= 1'b1;
                o_kind      <= o_cap_kind;
                o_last      <= cap_last;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end
endmodule

>>> rtl/kway_timestamp_merge_dedup.sv
// Merges up to SOURCES sorted streams by timestamp, removing duplicates.
// Depends on kwm_pkg, kwm_ctrl and kwm_datapath.
// A load is taken only while idle. A pop scans SOURCES heads, one a cycle
// through a single compare unit, then issues the point beat, or the empty
// marker if no head is present. The walk then steps a cursor one source a
// cycle while the output is free, up to the highest removed non-winner,
// issuing a refill beat at each removed one, and ends with the winner's
// refill. Each result beat that the receiver holds off holds the walk with
// it. Items are taken one at a time.
module kway_timestamp_merge_dedup #(
    parameter int SOURCES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [3:0]  i_source,
    input  logic [63:0] i_stamp,
    input  logic [63:0] i_payload,
    input  logic [31:0] i_sequence_req,
    input  logic        i_exhausted,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [63:0] o_out_stamp,
    output logic [63:0] o_out_payload,
    output logic [3:0]  o_req_source,
    output logic        o_last
);
    localparam int IW = $clog2(SOURCES);
    kwm_pkg::t_cmd cmd;
    kwm_pkg::t_sts sts;
    logic load, cap;
    logic [63:0] min_stamp, win_payload;
    logic [3:0]  win_src, walk_src;
    logic [1:0]  kind, cap_kind;
    logic        last;

    kwm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_opcode,
        .o_cmd(cmd), .i_sts(sts), .o_load(load),
        .o_out_valid(o_valid), .i_out_ready(i_ready),
        .o_kind(kind), .o_last(last), .o_cap(cap), .o_cap_kind(cap_kind)
    );

    kwm_datapath #(.SOURCES(SOURCES), .IW(IW)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_load(load && !i_exhausted), .i_source, .i_stamp, .i_payload,
        .i_sequence_req, .o_min_stamp(min_stamp), .o_win_payload(win_payload),
        .o_win_source(win_src), .o_walk_source(walk_src)
    );

    // capture output payload alongside the controller's kind/last
    always_ff @(posedge i_clk) begin
        if (cap) begin
            case (cap_kind)
                kwm_pkg::KIND_POINT: begin
                    o_out_stamp   <= min_stamp;
                    o_out_payload <= win_payload;
                    o_req_source  <= win_src;
                end
                kwm_pkg::KIND_REFILL: begin
                    o_out_stamp   <= '0;
                    o_out_payload <= '0;
                    o_req_source  <= sts.hit ? walk_src : win_src;
                end
                default: begin
                    o_out_stamp   <= '0;
                    o_out_payload <= '0;
                    o_req_source  <= '0;
                end
            endcase
        end
    end
    assign o_kind = kind;
    assign o_last = last;

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == kwm_pkg::KIND_EMPTY |-> o_last)
        else $error("empty result not last");
    a_point_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == kwm_pkg::KIND_POINT |-> !o_last)
        else $error("point flagged last");
    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan |-> !o_ready)
        else $error("ready during scan");
endmodule
